@@ sv/lennard_jones_pair_force_defines.svh @@
// Assertion macros shared by the Lennard-Jones pair force RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LENNARD_JONES_PAIR_FORCE_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LJPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LJPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ljpf_pkg.sv @@
// Shared constants, sideband payload type and helpers for the pair force pipe.
// No dependencies.
`default_nettype none

package ljpf_pkg;

	localparam int unsigned FRAC_BITS = 16;

	// divider dividend width: holds a 64-bit value shifted by 2*FRAC_BITS
	localparam int unsigned DIV_W = 64 + 2 * FRAC_BITS;
	localparam int unsigned Q_SHIFT = 32;

	localparam int unsigned ISQ_W = 48;
	localparam int unsigned ISQ_STEPS = ISQ_W / 2;
	localparam int unsigned ISQ_REM_W = ISQ_STEPS + 2;

	localparam logic [31:0] CUTOFF_RESET = 32'd196608;
	localparam logic [63:0] MAX47 = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] HALF_Q = 64'h0000_0000_8000_0000;

	localparam logic REG_CUTOFF = 1'b0;

	typedef struct packed {
		logic mode;
		logic skip;
		logic tneg;
		logic [2:0] dneg;
		logic [2:0][31:0] ad;
		logic [23:0] sig;
		logic [47:0] sig2;
		logic [23:0] eps;
		logic [63:0] csq;
		logic [63:0] r2;
		logic [63:0] q;
		logic [63:0] q3;
		logic [63:0] t;
		logic [63:0] amag;
	} pl_t;

	// floor(p / 2^sh), saturated to 64 bits
	function automatic logic [63:0] mul_sat(input logic [127:0] p, input int unsigned sh);
		logic [127:0] s;
		s = p >> sh;
		mul_sat = (|s[127:64]) ? '1 : s[63:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/ljpf_mul.sv @@
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on ljpf_pkg for the sideband payload type.
`default_nettype none

module ljpf_mul (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  ljpf_pkg::pl_t in_pl,
	output logic out_valid,
	output logic [127:0] prod,
	output ljpf_pkg::pl_t out_pl
);

	logic valid_s1;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	ljpf_pkg::pl_t pl_s1;
	logic [127:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			hh_s1 <= a[63:32] * b[63:32];
			pl_s1 <= in_pl;
			prod <= sum;
			out_pl <= pl_s1;
		end
	end

	assign sum = (128'(hh_s1) << 64) + (128'(lh_s1) << 32) + (128'(hl_s1) << 32)
		+ 128'(ll_s1);

endmodule

`default_nettype wire

@@ sv/ljpf_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on ljpf_pkg for widths and the sideband payload type.
`default_nettype none

module ljpf_isqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [ljpf_pkg::ISQ_W-1:0] rad,
	input  ljpf_pkg::pl_t in_pl,
	output logic out_valid,
	output logic [ljpf_pkg::ISQ_STEPS-1:0] root,
	output ljpf_pkg::pl_t out_pl
);

	localparam int unsigned N = ljpf_pkg::ISQ_STEPS;
	localparam int unsigned RW = ljpf_pkg::ISQ_REM_W;
	localparam int unsigned W = ljpf_pkg::ISQ_W;

	logic [N-1:0] valid_s;
	logic [N-1:0][W-1:0] rad_s;
	logic [N-1:0][RW-1:0] rem_s;
	logic [N-1:0][N-1:0] root_s;
	ljpf_pkg::pl_t pl_s [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic v_in;
			logic [W-1:0] rad_in;
			logic [RW-1:0] rem_in;
			logic [N-1:0] root_in;
			ljpf_pkg::pl_t pl_in;
			logic [RW+1:0] cur;
			logic [RW+1:0] trial;
			logic [RW+1:0] diff;
			logic ge;

			if (k == 0) begin : g_first
				assign v_in = in_valid;
				assign rad_in = rad;
				assign rem_in = '0;
				assign root_in = '0;
				assign pl_in = in_pl;
			end else begin : g_next
				assign v_in = valid_s[k-1];
				assign rad_in = rad_s[k-1];
				assign rem_in = rem_s[k-1];
				assign root_in = root_s[k-1];
				assign pl_in = pl_s[k-1];
			end

			assign cur = {rem_in, rad_in[W-1:W-2]};
			assign trial = {2'b00, root_in, 2'b01};
			assign ge = cur >= trial;
			assign diff = cur - trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= rad_in << 2;
					rem_s[k] <= ge ? diff[RW-1:0] : cur[RW-1:0];
					root_s[k] <= {root_in[N-2:0], ge};
					pl_s[k] <= pl_in;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[N-1];
	assign root = root_s[N-1];
	assign out_pl = pl_s[N-1];

endmodule

`default_nettype wire

@@ sv/ljpf_div.sv @@
// Pipelined restoring divider by the payload's r2, one quotient bit per stage.
// Depends on ljpf_pkg; quotient saturates to 64 bits.
`default_nettype none

module ljpf_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [ljpf_pkg::DIV_W-1:0] dividend,
	input  ljpf_pkg::pl_t in_pl,
	output logic out_valid,
	output logic [63:0] quot,
	output ljpf_pkg::pl_t out_pl
);

	localparam int unsigned W = ljpf_pkg::DIV_W;

	logic [W-1:0] valid_s;
	logic [W-1:0][W-1:0] work_s;
	logic [W-1:0][63:0] rem_s;
	ljpf_pkg::pl_t pl_s [W];

	genvar k;
	generate
		for (k = 0; k < W; k++) begin : g_step
			logic v_in;
			logic [W-1:0] work_in;
			logic [63:0] rem_in;
			ljpf_pkg::pl_t pl_in;
			logic [64:0] cur;
			logic [64:0] diff;
			logic ge;

			if (k == 0) begin : g_first
				assign v_in = in_valid;
				assign work_in = dividend;
				assign rem_in = '0;
				assign pl_in = in_pl;
			end else begin : g_next
				assign v_in = valid_s[k-1];
				assign work_in = work_s[k-1];
				assign rem_in = rem_s[k-1];
				assign pl_in = pl_s[k-1];
			end

			// work register shifts dividend bits out and quotient bits in
			assign cur = {rem_in, work_in[W-1]};
			assign ge = cur >= {1'b0, pl_in.r2};
			assign diff = cur - {1'b0, pl_in.r2};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[63:0] : cur[63:0];
					work_s[k] <= {work_in[W-2:0], ge};
					pl_s[k] <= pl_in;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[W-1];
	assign quot = (|work_s[W-1][W-1:64]) ? '1 : work_s[W-1][63:0];
	assign out_pl = pl_s[W-1];

endmodule

`default_nettype wire

@@ sv/lennard_jones_pair_force.sv @@
// Top level: Lennard-Jones 12-6 pair force pipeline with APB cutoff register.
// Depends on ljpf_pkg, ljpf_mul, ljpf_isqrt, ljpf_div and the defines header.
`default_nettype none
`include "lennard_jones_pair_force_defines.svh"

// Streams particle pairs in and 12-6 Lennard-Jones forces on the first
// particle out, one pair per clock while the output is not held. Every input
// beat gives exactly one output beat, in order; a skipped pair (coincident,
// too far to square, past the cutoff in mode 0, or outside 2^(1/6) sigma in
// mode 1) comes out with zero force and applied low. The pipe depth is set
// almost entirely by the two bit-per-stage dividers (sigma^2/r2 and A/r2),
// each 64 + 2*FRAC_BITS stages deep. The whole pipe advances together: it
// moves whenever the output register is empty or being taken, so
// s_axis_tready drops only while a finished beat is held by the sink. The
// cutoff register sits at byte address 0 and should be written while the
// pipe is empty.
module lennard_jones_pair_force (
	input  wire logic clk,
	input  wire logic arst_n,
	// APB config
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// pair input
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (32 each),
	// first_sigma, second_sigma, first_epsilon, second_epsilon (24 each)
	input  wire logic [287:0] s_axis_tdata,
	// mode
	input  wire logic [0:0] s_axis_tuser,
	// force output
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// force_x, force_y, force_z (48 each)
	output logic [143:0] m_axis_tdata,
	// applied
	output logic [0:0] m_axis_tuser
);

	localparam int unsigned F = ljpf_pkg::FRAC_BITS;
	localparam int unsigned DW = ljpf_pkg::DIV_W;

	logic en;
	logic cfg_wr;
	logic [31:0] cutoff_radius_q;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_radius_q <= ljpf_pkg::CUTOFF_RESET;
		end else if (cfg_wr && paddr[2] == ljpf_pkg::REG_CUTOFF) begin
			cutoff_radius_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == ljpf_pkg::REG_CUTOFF) ? cutoff_radius_q : '0;

	// global advance: output slot free or draining
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- S1: differences, mixing inputs ----------------
	logic [2:0][31:0] pos_a, pos_b;
	logic [2:0][32:0] dif;
	logic [23:0] sig_a, sig_b, eps_a, eps_b;
	logic [24:0] sig_sum;
	ljpf_pkg::pl_t pl1_d, pl_s1;
	logic valid_s1;
	logic [47:0] eprod_s1;

	assign pos_a[0] = s_axis_tdata[31:0];
	assign pos_a[1] = s_axis_tdata[63:32];
	assign pos_a[2] = s_axis_tdata[95:64];
	assign pos_b[0] = s_axis_tdata[127:96];
	assign pos_b[1] = s_axis_tdata[159:128];
	assign pos_b[2] = s_axis_tdata[191:160];
	assign sig_a = s_axis_tdata[215:192];
	assign sig_b = s_axis_tdata[239:216];
	assign eps_a = s_axis_tdata[263:240];
	assign eps_b = s_axis_tdata[287:264];
	assign sig_sum = {1'b0, sig_a} + {1'b0, sig_b};

	always_comb begin
		pl1_d = '0;
		pl1_d.mode = s_axis_tuser[0];
		for (int i = 0; i < 3; i++) begin
			dif[i] = {pos_a[i][31], pos_a[i]} - {pos_b[i][31], pos_b[i]};
			pl1_d.dneg[i] = dif[i][32];
			pl1_d.ad[i] = dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
		end
		// mode 0 mixes sigma by average, mode 1 uses the first particle's
		pl1_d.sig = s_axis_tuser[0] ? sig_a : sig_sum[24:1];
		pl1_d.eps = eps_a;
		pl1_d.csq = cutoff_radius_q * cutoff_radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl1_d;
			eprod_s1 <= eps_a * eps_b;
		end
	end

	// ---------------- geometric-mean epsilon ----------------
	logic sq_valid;
	logic [23:0] sq_root;
	ljpf_pkg::pl_t sq_pl;

	ljpf_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s1), .rad(eprod_s1), .in_pl(pl_s1),
		.out_valid(sq_valid), .root(sq_root), .out_pl(sq_pl)
	);

	// ---------------- S2: squares ----------------
	ljpf_pkg::pl_t pl2_d, pl_s2;
	logic valid_s2;
	logic [2:0][63:0] sq_s2;

	always_comb begin
		pl2_d = sq_pl;
		pl2_d.eps = sq_pl.mode ? sq_pl.eps : sq_root;
		pl2_d.sig2 = sq_pl.sig * sq_pl.sig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2 <= pl2_d;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= sq_pl.ad[i] * sq_pl.ad[i];
			end
		end
	end

	// ---------------- S3: r2, skip tests ----------------
	logic [65:0] r2_sum;
	ljpf_pkg::pl_t pl3_d, pl_s3;
	logic valid_s3;

	assign r2_sum = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);

	always_comb begin
		pl3_d = pl_s2;
		pl3_d.r2 = r2_sum[63:0];
		pl3_d.skip = (|r2_sum[65:64]) || (r2_sum[63:0] == '0)
			|| (!pl_s2.mode && (r2_sum[63:0] > pl_s2.csq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3 <= pl3_d;
		end
	end

	// ---------------- q = sigma^2 * 2^32 / r2 ----------------
	logic [DW-1:0] dvd1;
	logic d1_valid;
	logic [63:0] d1_quot;
	ljpf_pkg::pl_t d1_pl, m1_in_pl;

	assign dvd1 = DW'(pl_s3.sig2) << ljpf_pkg::Q_SHIFT;

	ljpf_div u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s3), .dividend(dvd1), .in_pl(pl_s3),
		.out_valid(d1_valid), .quot(d1_quot), .out_pl(d1_pl)
	);

	always_comb begin
		m1_in_pl = d1_pl;
		m1_in_pl.q = d1_quot;
	end

	// ---------------- q^3, q^6 ----------------
	logic m1_valid, m2_valid, m3_valid;
	logic [127:0] m1_prod, m2_prod, m3_prod;
	ljpf_pkg::pl_t m1_pl, m2_pl, m3_in_pl, m3_pl;
	logic [63:0] qq, q3v, q6v;

	ljpf_mul u_mul_qq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d1_valid), .a(d1_quot), .b(d1_quot), .in_pl(m1_in_pl),
		.out_valid(m1_valid), .prod(m1_prod), .out_pl(m1_pl)
	);

	assign qq = ljpf_pkg::mul_sat(m1_prod, 32);

	ljpf_mul u_mul_q3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(m1_valid), .a(qq), .b(m1_pl.q), .in_pl(m1_pl),
		.out_valid(m2_valid), .prod(m2_prod), .out_pl(m2_pl)
	);

	assign q3v = ljpf_pkg::mul_sat(m2_prod, 32);

	always_comb begin
		m3_in_pl = m2_pl;
		m3_in_pl.q3 = q3v;
	end

	ljpf_mul u_mul_q6 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(m2_valid), .a(q3v), .b(q3v), .in_pl(m3_in_pl),
		.out_valid(m3_valid), .prod(m3_prod), .out_pl(m3_pl)
	);

	assign q6v = ljpf_pkg::mul_sat(m3_prod, 32);

	// ---------------- S4: term 2*q6 - q3 ----------------
	logic [63:0] two6;
	ljpf_pkg::pl_t pl4_d, pl_s4;
	logic valid_s4;

	assign two6 = q6v[63] ? '1 : {q6v[62:0], 1'b0};

	always_comb begin
		pl4_d = m3_pl;
		if (q6v == '1) begin
			pl4_d.t = '1;
			pl4_d.tneg = 1'b0;
		end else if (two6 >= m3_pl.q3) begin
			pl4_d.t = two6 - m3_pl.q3;
			pl4_d.tneg = 1'b0;
		end else begin
			pl4_d.t = m3_pl.q3 - two6;
			pl4_d.tneg = 1'b1;
		end
		// repulsive-only: outside 2^(1/6) sigma when q^3 is at most one half
		if (m3_pl.mode && m3_pl.q3 <= ljpf_pkg::HALF_Q) begin
			pl4_d.skip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= m3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4 <= pl4_d;
		end
	end

	// ---------------- eps * T, times 24 ----------------
	logic m4_valid;
	logic [127:0] m4_prod;
	ljpf_pkg::pl_t m4_pl, pl5_d, pl_s5;
	logic [63:0] et;
	logic [68:0] et24;
	logic valid_s5;

	ljpf_mul u_mul_et (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s4), .a(64'(pl_s4.eps)), .b(pl_s4.t), .in_pl(pl_s4),
		.out_valid(m4_valid), .prod(m4_prod), .out_pl(m4_pl)
	);

	assign et = ljpf_pkg::mul_sat(m4_prod, F);
	assign et24 = (69'(et) << 4) + (69'(et) << 3);

	always_comb begin
		pl5_d = m4_pl;
		pl5_d.amag = (|et24[68:64]) ? '1 : et24[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= m4_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5 <= pl5_d;
		end
	end

	// ---------------- G = A * 2^(2F) / r2 ----------------
	logic [DW-1:0] dvd2;
	logic d2_valid;
	logic [63:0] g;
	ljpf_pkg::pl_t d2_pl;

	assign dvd2 = DW'(pl_s5.amag) << (2 * F);

	ljpf_div u_div_g (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s5), .dividend(dvd2), .in_pl(pl_s5),
		.out_valid(d2_valid), .quot(g), .out_pl(d2_pl)
	);

	// ---------------- per-axis G * |d| ----------------
	logic m5_valid, m5y_valid, m5z_valid;
	ljpf_pkg::pl_t m5_pl, m5y_pl, m5z_pl;
	logic [2:0][127:0] m5_prod;

	ljpf_mul u_mul_fx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d2_valid), .a(g), .b(64'(d2_pl.ad[0])), .in_pl(d2_pl),
		.out_valid(m5_valid), .prod(m5_prod[0]), .out_pl(m5_pl)
	);

	ljpf_mul u_mul_fy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d2_valid), .a(g), .b(64'(d2_pl.ad[1])), .in_pl(d2_pl),
		.out_valid(m5y_valid), .prod(m5_prod[1]), .out_pl(m5y_pl)
	);

	ljpf_mul u_mul_fz (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d2_valid), .a(g), .b(64'(d2_pl.ad[2])), .in_pl(d2_pl),
		.out_valid(m5z_valid), .prod(m5_prod[2]), .out_pl(m5z_pl)
	);

	// ---------------- clamp, sign, output register ----------------
	logic [2:0][63:0] fmag;
	logic [2:0][47:0] fval;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fmag[i] = ljpf_pkg::mul_sat(m5_prod[i], F + 8);
			if (fmag[i] > ljpf_pkg::MAX47) begin
				fmag[i] = ljpf_pkg::MAX47;
			end
			if (m5_pl.skip) begin
				fval[i] = '0;
			end else if (m5_pl.tneg ^ m5_pl.dneg[i]) begin
				fval[i] = 48'(-fmag[i]);
			end else begin
				fval[i] = fmag[i][47:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= m5_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {fval[2], fval[1], fval[0]};
			m_axis_tuser <= {!m5_pl.skip};
		end
	end

	// ---------------- checks ----------------
	`LJPF_ASSERT_IMP(a_skip_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata == '0, "skipped pair carries nonzero force")
	`LJPF_ASSERT_IMP(a_sym_clamp, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[47:0] != 48'h8000_0000_0000
		&& m_axis_tdata[95:48] != 48'h8000_0000_0000
		&& m_axis_tdata[143:96] != 48'h8000_0000_0000,
		"force component outside symmetric clamp")
	`LJPF_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_wr && paddr[2] == ljpf_pkg::REG_CUTOFF,
		cutoff_radius_q == $past(pwdata), "cutoff register not updated")
	`LJPF_ASSERT_IMP(a_axis_lockstep, clk, arst_n, m5_valid,
		m5y_valid && m5z_valid && m5y_pl == m5_pl && m5z_pl == m5_pl,
		"axis multipliers out of step")

endmodule

`default_nettype wire
